@@ rtl/msgpack_object_validator_top_defines.svh @@
// Assertion macros for the checker file of the validator.
`ifndef MSGPACK_OBJECT_VALIDATOR_TOP_DEFINES_SVH
`define MSGPACK_OBJECT_VALIDATOR_TOP_DEFINES_SVH

// Checked at every edge, reset included.
`define MOV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define MOV_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ rtl/mov_pkg.sv @@
// Shared types, codes and constants of the MessagePack object validator.
package mov_pkg;

  // Defaults.
  localparam int DEF_STACK_DEPTH = 32;
  localparam logic [5:0] MAX_NEST_RESET = 6'd32;

  // Frame status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCODE = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_TRAIL   = 3'd3;
  localparam logic [2:0] ST_DEEP    = 3'd4;

  // Header phases.
  localparam logic [2:0] PH_CODE = 3'd0;
  localparam logic [2:0] PH_BLEN = 3'd1;
  localparam logic [2:0] PH_ALEN = 3'd2;
  localparam logic [2:0] PH_MLEN = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;

  // Classes of a byte read as a type code.
  localparam logic [2:0] K_LEAF = 3'd0;
  localparam logic [2:0] K_SKIP = 3'd1;
  localparam logic [2:0] K_LEN  = 3'd2;
  localparam logic [2:0] K_CONT = 3'd3;
  localparam logic [2:0] K_BAD  = 3'd4;

  // Decoded type code: class, count (payload bytes, length bytes or children)
  // and the header phase that a length header enters.
  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] cnt;
    logic [2:0] lph;
  } dec_t;

  // One queued item between front and back.
  typedef struct packed {
    dec_t       dec;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

endpackage

@@ rtl/mov_fifo.sv @@
// Small synchronous queue of registers used between the parts of the block.
module mov_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  q_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          wr, rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = q_r[rp_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/mov_front.sv @@
// Front part: classifies each incoming byte as if it were a type code.
module mov_front import mov_pkg::*; (
  input  logic [7:0] data_byte,
  output dec_t       dec
);

  // Type code decode.
  always_comb begin
    dec = '{kind: K_BAD, cnt: 5'd0, lph: PH_CODE};
    if (data_byte <= 8'h7f || data_byte >= 8'he0 || data_byte == 8'hc0 ||
        data_byte == 8'hc2 || data_byte == 8'hc3) begin
      dec.kind = K_LEAF;
    end else if ((data_byte & 8'he0) == 8'ha0) begin
      dec.kind = K_SKIP;
      dec.cnt  = data_byte[4:0];
    end else if ((data_byte & 8'hf0) == 8'h90) begin
      dec.kind = K_CONT;
      dec.cnt  = {1'b0, data_byte[3:0]};
    end else if ((data_byte & 8'hf0) == 8'h80) begin
      dec.kind = K_CONT;
      dec.cnt  = {data_byte[3:0], 1'b0};
    end else begin
      case (data_byte)
        8'hc4, 8'hd9: dec = '{kind: K_LEN, cnt: 5'd1, lph: PH_BLEN};
        8'hc5, 8'hda: dec = '{kind: K_LEN, cnt: 5'd2, lph: PH_BLEN};
        8'hc6, 8'hdb: dec = '{kind: K_LEN, cnt: 5'd4, lph: PH_BLEN};
        8'hcc, 8'hd0: dec = '{kind: K_SKIP, cnt: 5'd1, lph: PH_CODE};
        8'hcd, 8'hd1, 8'hd4: dec = '{kind: K_SKIP, cnt: 5'd2, lph: PH_CODE};
        8'hd5: dec = '{kind: K_SKIP, cnt: 5'd3, lph: PH_CODE};
        8'hca, 8'hce, 8'hd2: dec = '{kind: K_SKIP, cnt: 5'd4, lph: PH_CODE};
        8'hd6: dec = '{kind: K_SKIP, cnt: 5'd5, lph: PH_CODE};
        8'hcb, 8'hcf, 8'hd3: dec = '{kind: K_SKIP, cnt: 5'd8, lph: PH_CODE};
        8'hd7: dec = '{kind: K_SKIP, cnt: 5'd9, lph: PH_CODE};
        8'hd8: dec = '{kind: K_SKIP, cnt: 5'd17, lph: PH_CODE};
        8'hdc: dec = '{kind: K_LEN, cnt: 5'd2, lph: PH_ALEN};
        8'hdd: dec = '{kind: K_LEN, cnt: 5'd4, lph: PH_ALEN};
        8'hde: dec = '{kind: K_LEN, cnt: 5'd2, lph: PH_MLEN};
        8'hdf: dec = '{kind: K_LEN, cnt: 5'd4, lph: PH_MLEN};
        default: dec = '{kind: K_BAD, cnt: 5'd0, lph: PH_CODE};
      endcase
    end
  end

endmodule

@@ rtl/mov_back.sv @@
// Back part: frame state, child-count stack and status of each frame.
module mov_back import mov_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [5:0] max_nesting,
  input  item_t      item,
  input  logic       item_valid,
  output logic       item_take,
  input  logic       res_full,
  output logic       res_push,
  output logic [2:0] res_status
);

  localparam int NLW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [6:0] SD7 = 7'(STACK_DEPTH);

  // Top-of-stack count lives in a register; buried counts live in memory
  // and never change while buried, so their is-one flags stay exact.
  logic [32:0]            mem [STACK_DEPTH];
  logic [32:0]            rdata_r;
  logic [32:0]            top_r, top_nxt;
  logic [STACK_DEPTH-1:0] ones_r, ones_nxt;
  logic [NLW-1:0]         nl_r, nl_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic [2:0]             lbl_r, lbl_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [31:0]            skip_r, skip_nxt;
  logic [2:0]             fst_r, fst_nxt;
  logic                   done_r, done_nxt;
  logic                   refill_r, refill_nxt;

  logic          go, ee, cont, sk;
  logic [32:0]   ch;
  logic [31:0]   skn;
  logic          wr_en, rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [6:0]    mx7, lim;
  logic          found;
  logic [AW-1:0] k_idx;

  assign go        = item_valid && !refill_r && !res_full;
  assign item_take = go;
  assign res_push  = go && item.last_byte;
  assign mx7       = {1'b0, max_nesting};
  assign lim       = (mx7 > SD7) ? SD7 : mx7;

  // Highest buried level whose count does not run out on this decrement.
  always_comb begin
    found = 1'b0;
    k_idx = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if ((NLW'(i) + NLW'(1)) < nl_r && !ones_r[i]) begin
        found = 1'b1;
        k_idx = AW'(i);
      end
    end
  end

  // Byte processing.
  always_comb begin
    top_nxt    = top_r;
    ones_nxt   = ones_r;
    nl_nxt     = nl_r;
    phase_nxt  = phase_r;
    lbl_nxt    = lbl_r;
    acc_nxt    = acc_r;
    skip_nxt   = skip_r;
    fst_nxt    = fst_r;
    done_nxt   = done_r;
    refill_nxt = 1'b0;
    ee         = 1'b0;
    cont       = 1'b0;
    sk         = 1'b0;
    ch         = '0;
    skn        = '0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    waddr      = AW'(nl_r - NLW'(1));
    raddr      = k_idx;
    res_status = ST_OK;

    // A pop to a buried level brings its count up from memory.
    if (refill_r) begin
      top_nxt = rdata_r - 33'd1;
    end

    if (go) begin
      if (fst_r != ST_OK) begin
        fst_nxt = fst_r;
      end else if (done_r) begin
        fst_nxt = ST_TRAIL;
      end else if (phase_r == PH_CODE) begin
        case (item.dec.kind)
          K_LEAF: ee = 1'b1;
          K_SKIP: begin
            sk  = 1'b1;
            skn = 32'(item.dec.cnt);
          end
          K_LEN: begin
            phase_nxt = item.dec.lph;
            lbl_nxt   = item.dec.cnt[2:0];
            acc_nxt   = '0;
          end
          K_CONT: begin
            cont = 1'b1;
            ch   = 33'(item.dec.cnt);
          end
          default: fst_nxt = ST_BADCODE;
        endcase
      end else if (phase_r == PH_SKIP) begin
        skip_nxt = skip_r - 32'd1;
        if (skip_nxt == '0) begin
          ee = 1'b1;
        end
      end else begin
        acc_nxt = {acc_r[23:0], item.data_byte};
        lbl_nxt = (lbl_r != '0) ? lbl_r - 3'd1 : 3'd0;
        if (lbl_nxt == '0) begin
          if (phase_r == PH_BLEN) begin
            sk  = 1'b1;
            skn = acc_nxt;
          end else if (phase_r == PH_ALEN) begin
            cont = 1'b1;
            ch   = {1'b0, acc_nxt};
          end else begin
            cont = 1'b1;
            ch   = {acc_nxt, 1'b0};
          end
        end
      end

      // Payload skip start.
      if (sk) begin
        if (skn == '0) begin
          ee = 1'b1;
        end else begin
          skip_nxt  = skn;
          phase_nxt = PH_SKIP;
        end
      end

      // Container start: push the old top below the new one.
      if (cont) begin
        if (ch == '0) begin
          ee = 1'b1;
        end else if (7'(nl_r) >= lim) begin
          fst_nxt = ST_DEEP;
        end else begin
          phase_nxt = PH_CODE;
          if (nl_r != '0) begin
            wr_en           = 1'b1;
            ones_nxt[waddr] = (top_r == 33'd1);
          end
          top_nxt = ch;
          nl_nxt  = nl_r + NLW'(1);
        end
      end

      // Element end: pop every level that finishes.
      if (ee) begin
        phase_nxt = PH_CODE;
        if (nl_r == '0) begin
          done_nxt = 1'b1;
        end else if (top_r != 33'd1) begin
          top_nxt = top_r - 33'd1;
        end else if (found) begin
          nl_nxt     = NLW'(k_idx) + NLW'(1);
          rd_en      = 1'b1;
          refill_nxt = 1'b1;
        end else begin
          nl_nxt   = '0;
          done_nxt = 1'b1;
        end
      end

      // Last byte: report and clear the frame.
      if (item.last_byte) begin
        res_status = (fst_nxt == ST_OK && !done_nxt) ? ST_TRUNC : fst_nxt;
        nl_nxt     = '0;
        phase_nxt  = PH_CODE;
        lbl_nxt    = '0;
        acc_nxt    = '0;
        skip_nxt   = '0;
        fst_nxt    = ST_OK;
        done_nxt   = 1'b0;
        refill_nxt = 1'b0;
      end
    end
  end

  // Stack memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= top_r;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // Top count is payload.
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  // Frame control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r   <= '0;
      nl_r     <= '0;
      phase_r  <= PH_CODE;
      lbl_r    <= '0;
      acc_r    <= '0;
      skip_r   <= '0;
      fst_r    <= ST_OK;
      done_r   <= 1'b0;
      refill_r <= 1'b0;
    end else begin
      ones_r   <= ones_nxt;
      nl_r     <= nl_nxt;
      phase_r  <= phase_nxt;
      lbl_r    <= lbl_nxt;
      acc_r    <= acc_nxt;
      skip_r   <= skip_nxt;
      fst_r    <= fst_nxt;
      done_r   <= done_nxt;
      refill_r <= refill_nxt;
    end
  end

endmodule

@@ rtl/msgpack_object_validator_top.sv @@
// Top level of the MessagePack object validator.
// Usage:
//   Bytes of a frame enter on in_data_byte with in_last_byte marking the final
//   byte; an item is taken at an edge with in_push high and in_full low.
//   For every frame exactly one status item comes out on out_status (ok, bad
//   type code, truncated, trailing bytes, too deep); it waits while out_empty
//   is low and leaves at an edge with out_pop high.
//   cfg_we with cfg_wdata sets max_nesting (32 after reset); write it only
//   while no frame is in flight.
// Result path and throughput:
//   A status item is pushed into the result queue when the back part takes
//   its last byte from the input queue, and out_empty falls with that push.
//   One byte per cycle is sustained while the result queue has room; a byte
//   that closes levels down to a buried container stalls the back part for
//   the read of that level's child count from the stack memory.
// Reset and stalls:
//   Reset empties both queues and clears all frame state. When the receiver
//   stops popping, the result queue fills, the back part halts and the input
//   queue raises in_full after two more bytes.
module msgpack_object_validator_top import mov_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_status,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);

  localparam int IW = $bits(item_t);

  logic [5:0] max_nesting_r;
  dec_t       dec;
  item_t      in_item, q_item;
  logic       q_empty, q_take;
  logic       res_full, res_push;
  logic [2:0] res_status;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_nesting_r <= MAX_NEST_RESET;
    end else if (cfg_we) begin
      max_nesting_r <= cfg_wdata;
    end
  end

  // Front: classify the byte on entry.
  mov_front u_front (
    .data_byte (in_data_byte),
    .dec       (dec)
  );

  assign in_item = '{dec: dec, data_byte: in_data_byte, last_byte: in_last_byte};

  // Queue between front and back.
  mov_fifo #(.W(IW), .DEPTH(2)) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_item),
    .full  (in_full),
    .pop   (q_take),
    .rdata (q_item),
    .empty (q_empty)
  );

  // Back: frame state and stack.
  mov_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_nesting (max_nesting_r),
    .item        (q_item),
    .item_valid  (!q_empty),
    .item_take   (q_take),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_status  (res_status)
  );

  // Result queue.
  mov_fifo #(.W(3), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_status),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_status),
    .empty (out_empty)
  );

endmodule

@@ rtl/mov_checker.sv @@
// Port-level checker of the validator and its bind to the top level.
`include "msgpack_object_validator_top_defines.svh"

module mov_checker import mov_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_status
);

  // Reset leaves both queues empty.
  `MOV_ASSERT(a_reset_empty, !rst_n |=> (out_empty && !in_full), "queues not empty after reset")

  // A status item carries one of the five codes, which run from ok to too deep.
  `MOV_ASSERT_RUN(a_status_range, !out_empty |-> (out_status <= ST_DEEP), "status code out of range")

  // A waiting item that is not taken stays and holds its value.
  `MOV_ASSERT_RUN(a_result_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)), "waiting status item changed")

endmodule

bind msgpack_object_validator_top mov_checker u_chk (.*);
